FILE: design/first_fit_free_list_allocator_defines.svh
// Assertion macros for the first-fit free-list allocator.
// Clock and reset are taken from i_clk and i_rst_n in the using scope.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FFA_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

FILE: design/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
package ffa_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned CNT_W  = 13;
    localparam logic [31:0] ROUND_ADD  = 32'h0000_0fff;
    localparam logic [31:0] ROUND_MASK = 32'hffff_f000;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FAIL = 2'd1;
    localparam logic [1:0] STATUS_LOST = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
    } t_entry;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN_RD,
        CMD_SCAN_EV,
        CMD_ALLOC,
        CMD_FAIL,
        CMD_FREE,
        CMD_DEL_RD,
        CMD_DEL_WR,
        CMD_INS_RD,
        CMD_INS_WR,
        CMD_INS_PUT,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic fit;
        logic past;
        logic at_end;
        logic len_eq;
        logic merge_prev;
        logic merge_next;
        logic full;
        logic n_eq_used;
        logic n_eq_k;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] lost_bytes;
        logic [ADDR_W-1:0] lost_count;
        logic [CNT_W-1:0]  peak_entries;
        logic [CNT_W-1:0]  entry_count;
        logic [ADDR_W-1:0] total_free;
        logic [1:0]        status;
        logic [ADDR_W-1:0] alloc_addr;
    } t_result;

endpackage

FILE: design/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator with coalescing.
// Depends on ffa_pkg, ffa_ctrl and ffa_dpath.
//
// Input stream: one transfer per request, allocate or free (tuser[0]),
// optional round-up of the size to 4 KiB (tuser[1]), address and size in tdata.
// Output stream: one transfer per request with the allocated address, status
// and the running statistics as they stand after the request.
// The table is one single-port-write, registered-read memory of TABLE_ENTRIES
// (start, length) pairs, kept sorted by start address.
// Each request scans the table entries in order, and an insert or delete shifts
// the entries behind the position one at a time. One request is in work at a time.
// The result sits in an output register; the next request is accepted while it
// waits. If the receiver stalls, the block finishes the request and then holds
// until the waiting result is taken.
// Reset clears the counts and statistics; table contents need no clearing.
module first_fit_free_list_allocator #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // region_addr, region_size
    input  logic [1:0]   s_axis_tuser,   // func, round_4k
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // alloc_addr, total_free, entry_count,
                                         // peak_entries, lost_count, lost_bytes
    output logic [1:0]   m_axis_tuser    // status
);
    import ffa_pkg::*;

    t_cmd    cmd;
    t_status st;
    t_result res;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    ffa_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (s_axis_tuser[0]),
        .i_round_4k    (s_axis_tuser[1]),
        .i_region_addr (s_axis_tdata[31:0]),
        .i_region_size (s_axis_tdata[63:32]),
        .i_out_ready   (m_axis_tready),
        .o_st          (st),
        .o_out_valid   (m_axis_tvalid),
        .o_res         (res)
    );

    assign m_axis_tdata = {6'd0, res.lost_bytes, res.lost_count, res.peak_entries,
                           res.entry_count, res.total_free, res.alloc_addr};
    assign m_axis_tuser = res.status;

endmodule

FILE: design/ffa_ctrl.sv
// Controller state machine for the first-fit free-list allocator.
// Depends on ffa_pkg; drives commands into ffa_dpath.
module ffa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ffa_pkg::t_status i_st,
    output ffa_pkg::t_cmd    o_cmd,
    output logic             o_in_ready
);
    import ffa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SCAN_RD = 11'b000_0000_0010,
        S_SCAN_EV = 11'b000_0000_0100,
        S_ALLOC   = 11'b000_0000_1000,
        S_FAIL    = 11'b000_0001_0000,
        S_FREE    = 11'b000_0010_0000,
        S_DEL_RD  = 11'b000_0100_0000,
        S_DEL_WR  = 11'b000_1000_0000,
        S_INS_RD  = 11'b001_0000_0000,
        S_INS_WR  = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_st.at_end) begin
                    n_state = i_st.is_free ? S_FREE : S_FAIL;
                end else begin
                    o_cmd   = CMD_SCAN_RD;
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                o_cmd = CMD_SCAN_EV;
                if (i_st.is_free) begin
                    n_state = i_st.past ? S_FREE : S_SCAN_RD;
                end else begin
                    n_state = i_st.fit ? S_ALLOC : S_SCAN_RD;
                end
            end
            S_ALLOC: begin
                o_cmd   = CMD_ALLOC;
                n_state = i_st.len_eq ? S_DEL_RD : S_OUT;
            end
            S_FAIL: begin
                o_cmd   = CMD_FAIL;
                n_state = S_OUT;
            end
            S_FREE: begin
                o_cmd = CMD_FREE;
                if (i_st.merge_prev && i_st.merge_next) begin
                    n_state = S_DEL_RD;
                end else if (i_st.merge_prev || i_st.merge_next || i_st.full) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_DEL_RD: begin
                if (i_st.n_eq_used) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd   = CMD_DEL_RD;
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd   = CMD_DEL_WR;
                n_state = S_DEL_RD;
            end
            S_INS_RD: begin
                if (i_st.n_eq_k) begin
                    o_cmd   = CMD_INS_PUT;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = CMD_INS_RD;
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd   = CMD_INS_WR;
                n_state = S_INS_RD;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/ffa_dpath.sv
// Datapath of the first-fit free-list allocator: region table, counters, result register.
// Depends on ffa_pkg; commanded by ffa_ctrl.
module ffa_dpath #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffa_pkg::t_cmd    i_cmd,
    input  logic             i_func,
    input  logic             i_round_4k,
    input  logic [31:0]      i_region_addr,
    input  logic [31:0]      i_region_size,
    input  logic             i_out_ready,
    output ffa_pkg::t_status o_st,
    output logic             o_out_valid,
    output ffa_pkg::t_result o_res
);
    import ffa_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;
    t_entry r_prev;

    logic              r_func;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_size;
    logic [ADDR_W-1:0] r_got;
    logic [1:0]        r_status;
    logic [CW-1:0]     r_k;
    logic [CW-1:0]     r_n;
    logic              r_have_prev;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_peak;
    logic [ADDR_W-1:0] r_lost_cnt;
    logic [ADDR_W-1:0] r_lost_bytes;
    logic [ADDR_W-1:0] r_free_sum;
    logic              r_out_valid;
    t_result           r_res;

    logic [ADDR_W-1:0] n_size;
    logic              we;
    logic              re;
    logic [CW-1:0]     waddr;
    logic [CW-1:0]     raddr;
    t_entry            wdata;
    logic              mp;
    logic              mn;
    logic              full;
    logic [CW-1:0]     used_inc;

    assign n_size   = i_round_4k ? ((i_region_size + ROUND_ADD) & ROUND_MASK) : i_region_size;
    assign mp       = r_have_prev && ((r_prev.start + r_prev.len) == r_addr);
    assign mn       = (r_k != r_used) && ((r_addr + r_size) == r_rdata.start);
    assign full     = (r_used == CW'(TABLE_ENTRIES));
    assign used_inc = r_used + 1'b1;

    assign o_st.is_free    = r_func;
    assign o_st.fit        = (r_rdata.len >= r_size);
    assign o_st.past       = (r_rdata.start > r_addr);
    assign o_st.at_end     = (r_k == r_used);
    assign o_st.len_eq     = (r_rdata.len == r_size);
    assign o_st.merge_prev = mp;
    assign o_st.merge_next = mn;
    assign o_st.full       = full;
    assign o_st.n_eq_used  = (r_n == r_used);
    assign o_st.n_eq_k     = (r_n == r_k);
    assign o_st.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        we          = 1'b0;
        re          = 1'b0;
        waddr       = r_k;
        raddr       = r_k;
        wdata.start = r_addr;
        wdata.len   = r_size;
        case (i_cmd)
            CMD_SCAN_RD: begin
                re = 1'b1;
            end
            CMD_ALLOC: begin
                we          = !o_st.len_eq;
                wdata.start = r_rdata.start + r_size;
                wdata.len   = r_rdata.len - r_size;
            end
            CMD_FREE: begin
                if (mp) begin
                    we          = 1'b1;
                    waddr       = r_k - 1'b1;
                    wdata.start = r_prev.start;
                    wdata.len   = r_prev.len + r_size + (mn ? r_rdata.len : '0);
                end else if (mn) begin
                    we        = 1'b1;
                    wdata.len = r_rdata.len + r_size;
                end
            end
            CMD_DEL_RD: begin
                re    = 1'b1;
                raddr = r_n + 1'b1;
            end
            CMD_INS_RD: begin
                re    = 1'b1;
                raddr = r_n - 1'b1;
            end
            CMD_DEL_WR, CMD_INS_WR: begin
                we    = 1'b1;
                waddr = r_n;
                wdata = r_rdata;
            end
            CMD_INS_PUT: begin
                we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr[IW-1:0]] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_func      <= i_func;
                r_addr      <= i_region_addr;
                r_size      <= n_size;
                r_k         <= '0;
                r_have_prev <= 1'b0;
                r_got       <= '0;
                r_status    <= STATUS_OK;
            end
            CMD_SCAN_EV: begin
                if (r_func) begin
                    if (!o_st.past) begin
                        r_prev      <= r_rdata;
                        r_have_prev <= 1'b1;
                        r_k         <= r_k + 1'b1;
                    end
                end else if (!o_st.fit) begin
                    r_k <= r_k + 1'b1;
                end
            end
            CMD_ALLOC: begin
                r_got <= r_rdata.start;
                r_n   <= r_k;
            end
            CMD_FAIL: begin
                r_status <= STATUS_FAIL;
            end
            CMD_FREE: begin
                r_n <= mp ? r_k : r_used;
                if (!mp && !mn && full) begin
                    r_status <= STATUS_LOST;
                end
            end
            CMD_DEL_WR: begin
                r_n <= r_n + 1'b1;
            end
            CMD_INS_WR: begin
                r_n <= r_n - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_peak       <= '0;
            r_lost_cnt   <= '0;
            r_lost_bytes <= '0;
            r_free_sum   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd == CMD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_ALLOC: begin
                    r_free_sum <= r_free_sum - r_size;
                    if (o_st.len_eq) begin
                        r_used <= r_used - 1'b1;
                    end
                end
                CMD_FREE: begin
                    if (mp || mn) begin
                        r_free_sum <= r_free_sum + r_size;
                        if (mp && mn) begin
                            r_used <= r_used - 1'b1;
                        end
                    end else if (!full) begin
                        r_free_sum <= r_free_sum + r_size;
                        r_used     <= used_inc;
                        if (r_peak < used_inc) begin
                            r_peak <= used_inc;
                        end
                    end else begin
                        r_lost_cnt   <= r_lost_cnt + 1'b1;
                        r_lost_bytes <= r_lost_bytes + r_size;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_OUT) begin
            r_res.alloc_addr   <= r_got;
            r_res.status       <= r_status;
            r_res.total_free   <= r_free_sum;
            r_res.entry_count  <= CNT_W'(r_used);
            r_res.peak_entries <= CNT_W'(r_peak);
            r_res.lost_count   <= r_lost_cnt;
            r_res.lost_bytes   <= r_lost_bytes;
        end
    end

endmodule

FILE: design/ffa_checker.sv
// Port-level checks for the first-fit free-list allocator, bound to the top level.
// Depends on first_fit_free_list_allocator_defines.svh.
`include "first_fit_free_list_allocator_defines.svh"

module ffa_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [63:0]  s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    `FFA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")
    `FFA_ASSERT_IMP(a_fail_addr, m_axis_tvalid && (m_axis_tuser == 2'd1 || m_axis_tuser == 2'd2), m_axis_tdata[31:0] == 32'd0, "failed request reports nonzero address")
    `FFA_ASSERT_IMP(a_peak, m_axis_tvalid, m_axis_tdata[76:64] <= m_axis_tdata[89:77], "entry count above peak")
    `FFA_ASSERT_NXT(a_no_back, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request accepted while busy")

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);

FILE: tb/sv/first_fit_free_list_allocator_tb.sv
// Testbench for the first-fit free-list allocator: drives allocate and free requests,
// predicts each result from a behavioral copy of the region table and compares them.
// Depends on ffa_pkg and first_fit_free_list_allocator.
module first_fit_free_list_allocator_tb;
    import ffa_pkg::*;

    localparam int unsigned SLOTS = 4096;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    first_fit_free_list_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    logic [31:0] reg_start [SLOTS];
    logic [31:0] reg_len [SLOTS];
    int unsigned n_regions = 0;
    int unsigned n_peak = 0;
    logic [31:0] sum_free = '0;
    logic [31:0] drop_cnt = '0;
    logic [31:0] drop_bytes = '0;
    t_result expected_results[$];
    int errors = 0;
    bit stall_on = 1'b1;

    task automatic drop_region(input int unsigned k);
        for (int unsigned n = k; n + 1 < n_regions; n++) begin
            reg_start[n] = reg_start[n + 1];
            reg_len[n] = reg_len[n + 1];
        end
        n_regions--;
    endtask

    task automatic predict_request(input logic op, input logic rnd, input logic [31:0] addr,
                                   input logic [31:0] size_in);
        t_result r;
        logic [31:0] size;
        int unsigned k;
        bit done;
        r = '0;
        done = 1'b0;
        size = rnd ? ((size_in + ROUND_ADD) & ROUND_MASK) : size_in;
        if (op == OP_ALLOC) begin
            r.status = STATUS_FAIL;
            for (k = 0; k < n_regions && !done; k++) begin
                if (reg_len[k] >= size) begin
                    done = 1'b1;
                    r.status = STATUS_OK;
                    r.alloc_addr = reg_start[k];
                    reg_start[k] += size;
                    reg_len[k] -= size;
                    if (reg_len[k] == 0) drop_region(k);
                    sum_free -= size;
                end
            end
        end else begin
            r.status = STATUS_OK;
            for (k = 0; k < n_regions; k++) begin
                if (reg_start[k] > addr) break;
            end
            if (k > 0 && reg_start[k-1] + reg_len[k-1] == addr) begin
                reg_len[k-1] += size;
                if (k < n_regions && addr + size == reg_start[k]) begin
                    reg_len[k-1] += reg_len[k];
                    drop_region(k);
                end
                sum_free += size;
            end else if (k < n_regions && addr + size == reg_start[k]) begin
                reg_start[k] = addr;
                reg_len[k] += size;
                sum_free += size;
            end else if (n_regions < SLOTS) begin
                for (int unsigned n = n_regions; n > k; n--) begin
                    reg_start[n] = reg_start[n-1];
                    reg_len[n] = reg_len[n-1];
                end
                n_regions++;
                if (n_peak < n_regions) n_peak = n_regions;
                reg_start[k] = addr;
                reg_len[k] = size;
                sum_free += size;
            end else begin
                drop_cnt++;
                drop_bytes += size;
                r.status = STATUS_LOST;
            end
        end
        r.total_free = sum_free;
        r.entry_count = n_regions[CNT_W-1:0];
        r.peak_entries = n_peak[CNT_W-1:0];
        r.lost_count = drop_cnt;
        r.lost_bytes = drop_bytes;
        expected_results.push_back(r);
    endtask

    task automatic send_request(input logic op, input logic rnd, input logic [31:0] addr,
                                input logic [31:0] size);
        if (stall_on && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {rnd, op};
        s_axis_tdata <= {size, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(op, rnd, addr, size);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && stall_on && $urandom_range(3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(16, 1)) @(posedge i_clk);
            end
            m_axis_tready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[153:122], m_axis_tdata[121:90], m_axis_tdata[89:77],
                   m_axis_tdata[76:64], m_axis_tdata[63:32], m_axis_tuser,
                   m_axis_tdata[31:0]};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.alloc_addr !== exp_r.alloc_addr)
                    $display("%0t: alloc_addr exp %h got %h", $time,
                             exp_r.alloc_addr, got.alloc_addr);
                if (got.status !== exp_r.status)
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                if (got.total_free !== exp_r.total_free)
                    $display("%0t: total_free exp %h got %h", $time,
                             exp_r.total_free, got.total_free);
                if (got.entry_count !== exp_r.entry_count)
                    $display("%0t: entry_count exp %0d got %0d", $time,
                             exp_r.entry_count, got.entry_count);
                if (got.peak_entries !== exp_r.peak_entries)
                    $display("%0t: peak_entries exp %0d got %0d", $time,
                             exp_r.peak_entries, got.peak_entries);
                if (got.lost_count !== exp_r.lost_count)
                    $display("%0t: lost_count exp %h got %h", $time,
                             exp_r.lost_count, got.lost_count);
                if (got.lost_bytes !== exp_r.lost_bytes)
                    $display("%0t: lost_bytes exp %h got %h", $time,
                             exp_r.lost_bytes, got.lost_bytes);
                if (got !== exp_r) errors++;
            end
        end
    end

    task automatic test_directed();
        send_request(OP_ALLOC, 1'b0, 32'hffff_ffff, 32'd0);
        send_request(OP_ALLOC, 1'b1, 32'h0, 32'd1);
        send_request(OP_FREE, 1'b0, 32'h0000_0000, 32'h0000_1000);
        send_request(OP_ALLOC, 1'b0, 32'h0, 32'd0);
        send_request(OP_FREE, 1'b0, 32'h0000_3000, 32'h0000_1000);
        send_request(OP_FREE, 1'b0, 32'h0000_1000, 32'h0000_2000);
        send_request(OP_FREE, 1'b1, 32'h0001_0000, 32'h0000_0001);
        send_request(OP_FREE, 1'b1, 32'h0000_f000, 32'h0000_0fff);
        send_request(OP_FREE, 1'b0, 32'h8000_0000, 32'd0);
        send_request(OP_ALLOC, 1'b0, 32'h0, 32'd0);
        send_request(OP_FREE, 1'b0, 32'hffff_f000, 32'h0000_1000);
        send_request(OP_FREE, 1'b1, 32'hffff_ffff, 32'hffff_f001);
        send_request(OP_ALLOC, 1'b0, 32'h0, 32'hffff_ffff);
        send_request(OP_ALLOC, 1'b1, 32'h0, 32'h0000_1800);
        send_request(OP_ALLOC, 1'b0, 32'h0, 32'h0000_1000);
        send_request(OP_FREE, 1'b0, 32'h0000_0000, 32'h0000_2000);
        send_request(OP_FREE, 1'b0, 32'h0000_0000, 32'h0000_2000);
        send_request(OP_ALLOC, 1'b0, 32'h0, 32'h0000_0123);
    endtask

    task automatic test_random();
        logic [31:0] a, s;
        for (int i = 0; i < 100; i++) begin
            case ($urandom_range(5))
                0: begin
                    a = $urandom;
                    s = $urandom;
                end
                1, 2: begin
                    a = {20'($urandom_range(63)), 12'h0};
                    s = {20'($urandom_range(4)), 12'h0};
                end
                default: begin
                    a = $urandom_range(4095);
                    s = $urandom_range(4095);
                end
            endcase
            if (i > 80) stall_on = 1'b0;
            send_request(logic'($urandom_range(1)), logic'($urandom_range(1)), a, s);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (errors == 0) $display("first_fit_free_list_allocator test passed");
        else $display("first_fit_free_list_allocator test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("first_fit_free_list_allocator test failed");
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/ffa_pkg.sv
design/ffa_ctrl.sv
design/ffa_dpath.sv
design/first_fit_free_list_allocator.sv
design/ffa_checker.sv
tb/sv/first_fit_free_list_allocator_tb.sv
